@@ hw/rtl/circular_deque_defines.svh @@
// Assertion macros used by the circular deque checker file.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Clocked assertion, muted while reset is high
`define CDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define CDQ_ASSERT_ANY(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/cdq_pkg.sv @@
// Shared types, codes and constants for the circular deque.
package cdq_pkg;

   // Default ring depth and capacity register
   localparam int DEPTH_DEF = 16;
   localparam int CAP_W     = 5;
   localparam int CAP_RESET = 16;

   // Field widths
   localparam int OP_W   = 3;
   localparam int DATA_W = 32;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_BITS     = OP_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS     = 1 + DATA_W + DATA_W + 1 + 1;
   localparam int RSP_TDATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_READ = 4'b0100,
      ST_LOAD = 4'b1000
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec;
      logic capture;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

@@ hw/rtl/circular_deque.sv @@
// Top level of the circular deque: controller plus datapath.
//
//  channel   direction  handshake              payload
//  req_      in         req_tvalid/req_tready  tdata: operation, value
//  rsp_      out        rsp_tvalid/rsp_tready  tdata: accepted, front, rear, empty, full
//  csr_      in         csr_valid/csr_ready    csr_data: capacity
//
// A request passes in order through latch, execute, ring read and result load;
// the ring's registered read adds the read step. The next request is taken only
// after the last one has been loaded into the result register.
// A finished result waits in its own register; while it is unread the next request
// holds in result load and the request side stays closed.
// Synchronous reset empties the deque at capacity min(16, DEPTH); a capacity write also empties it.
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] operation, [34:3] value, [39:35] zero
   input  logic [cdq_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] accepted, [32:1] front_value, [64:33] rear_value,
   // [65] is_empty, [66] is_full, [71:67] zero
   output logic [cdq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cdq_pkg::CAP_W-1:0]       csr_data
);
   import cdq_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cdq_ctrl u_cdq_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cdq_dpath #(
      .DEPTH (DEPTH)
   ) u_cdq_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hw/rtl/cdq_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a_ff,
   output logic [WIDTH-1:0] rd_data_b_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word, read two words
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

endmodule

@@ hw/rtl/cdq_ctrl.sv @@
// Controller state machine for the circular deque.
module cdq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  cdq_pkg::status_type status,
   output cdq_pkg::cmd_type    cmd
);
   import cdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Sequence one request: latch, execute, read ring, load result
   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.exec     = 1'b0;
      cmd.capture  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/cdq_dpath.sv @@
// Datapath for the circular deque: pointers, ring memory, result register.
module cdq_dpath #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cdq_pkg::cmd_type                cmd,
   output cdq_pkg::status_type             status,
   input  logic [cdq_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            csr_valid,
   input  logic [cdq_pkg::CAP_W-1:0]       csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cdq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cdq_pkg::*;

   localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RST_CAP = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;
   localparam logic [IW-1:0] RESET_LAST = IW'(RST_CAP - 1);

   // Latched request
   logic [OP_W-1:0]   op_ff;
   logic [DATA_W-1:0] value_ff;

   // Deque state
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic          empty_ff, empty_in;
   logic [IW-1:0] last_ff;
   logic          ok_ff, ok_in;

   // Ring access
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [DATA_W-1:0] rd_front, rd_rear;

   // Result register
   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [DATA_W-1:0] rsp_front_ff;
   logic [DATA_W-1:0] rsp_rear_ff;
   logic              rsp_empty_ff;
   logic              rsp_full_ff;

   logic [IW-1:0] head_up, head_dn, tail_up, tail_dn;
   logic          full;
   logic [IW-1:0] csr_last;
   logic [31:0]   csr_wide;

   // Wrap pointers at the effective capacity
   assign head_up = (head_ff == last_ff) ? '0 : head_ff + IW'(1);
   assign head_dn = (head_ff == '0) ? last_ff : head_ff - IW'(1);
   assign tail_up = (tail_ff == last_ff) ? '0 : tail_ff + IW'(1);
   assign tail_dn = (tail_ff == '0) ? last_ff : tail_ff - IW'(1);
   assign full    = !empty_ff && (tail_up == head_ff);

   // Clamp written capacity to 1..DEPTH, keep it as last index
   assign csr_wide = 32'(csr_data);
   always_comb begin
      if (csr_wide == 32'd0) begin
         csr_last = '0;
      end else if (csr_wide > 32'(DEPTH)) begin
         csr_last = IW'(DEPTH - 1);
      end else begin
         csr_last = IW'(csr_wide - 32'd1);
      end
   end

   // Apply the operation to pointers and ring
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      ok_in    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (!full) begin
               ok_in = 1'b1;
               wr_en = cmd.exec;
               if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  wr_addr  = '0;
               end else if (op_ff == OP_PUSH_FRONT) begin
                  head_in = head_dn;
                  wr_addr = head_dn;
               end else begin
                  tail_in = tail_up;
                  wr_addr = tail_up;
               end
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (!empty_ff) begin
               ok_in = 1'b1;
               if (head_ff == tail_ff) begin
                  empty_in = 1'b1;
               end else if (op_ff == OP_POP_FRONT) begin
                  head_in = head_up;
               end else begin
                  tail_in = tail_dn;
               end
            end
         end
         OP_PEEK: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // Latch the request
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_tdata[OP_W-1:0];
         value_ff <= req_tdata[OP_W +: DATA_W];
      end
   end

   // Update deque state; a capacity write empties the deque
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         last_ff  <= RESET_LAST;
         ok_ff    <= 1'b0;
      end else if (csr_valid) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         last_ff  <= csr_last;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         ok_ff    <= ok_in;
      end
   end

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH),
      .AW    (IW)
   ) u_cdq_ram (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (value_ff),
      .rd_addr_a    (head_ff),
      .rd_addr_b    (tail_ff),
      .rd_data_a_ff (rd_front),
      .rd_data_b_ff (rd_rear)
   );

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.capture) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rsp_ok_ff    <= ok_ff;
         rsp_front_ff <= empty_ff ? '1 : rd_front;
         rsp_rear_ff  <= empty_ff ? '1 : rd_rear;
         rsp_empty_ff <= empty_ff;
         rsp_full_ff  <= full;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {(RSP_TDATA_W - RSP_BITS)'(0), rsp_full_ff, rsp_empty_ff,
                             rsp_rear_ff, rsp_front_ff, rsp_ok_ff};

endmodule

@@ hw/rtl/cdq_checker.sv @@
// Port-level checker for the circular deque, bound to the top level.
`include "circular_deque_defines.svh"

module cdq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cdq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // Reset leaves no result pending and opens the request side
   `CDQ_ASSERT_ANY(a_reset_clean, reset |=> (!rsp_tvalid && req_tready), "reset state wrong")

   // Only one request in flight
   `CDQ_ASSERT(a_one_in_flight, (req_tvalid && req_tready) |=> !req_tready, "second request taken")

   // An empty deque shows all ones for front and rear
   `CDQ_ASSERT(a_empty_marks, (rsp_tvalid && rsp_tdata[65]) |->
      ((rsp_tdata[32:1] == 32'hFFFF_FFFF) && (rsp_tdata[64:33] == 32'hFFFF_FFFF)),
      "empty result without marker values")

   // Empty and full never both
   `CDQ_ASSERT(a_empty_not_full, rsp_tvalid |-> !(rsp_tdata[65] && rsp_tdata[66]),
      "empty and full together")

   // A stalled result holds
   `CDQ_ASSERT(a_rsp_hold, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)),
      "stalled result changed")

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

@@ tb/circular_deque_tb.sv @@
// Testbench for the circular deque: stream stimulus, response scoreboard and verdict.
`timescale 1ns / 100ps

module circular_deque_tb;
   import cdq_pkg::*;

   // Codes outside the defined operation set
   localparam logic [OP_W-1:0] OP_BAD_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_BAD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_BAD_7 = 3'd7;

   localparam int ITEMS_PER_PHASE  = 50;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int REPORT_LIMIT     = 10;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CAP_W-1:0]       csr_data   = '0;

   int unsigned burst_left  = 0;
   bit          hold_toggle = 1'b0;

   typedef struct {
      logic              accepted;
      logic [DATA_W-1:0] front_value;
      logic [DATA_W-1:0] rear_value;
      logic              is_empty;
      logic              is_full;
   } deque_result_type;

   // Deque predictor plus the queue of results it expects
   class deque_scoreboard_type;
      logic [DATA_W-1:0] ring [DEPTH_DEF];
      int unsigned       head_idx;
      int unsigned       tail_idx;
      int unsigned       capacity;
      bit                empty_now;
      deque_result_type  awaited[$];
      int unsigned       failures;

      function new();
         foreach (ring[i]) ring[i] = '0;
         capacity = CAP_RESET;
         failures = 0;
         clear_ring();
      endfunction

      function void clear_ring();
         head_idx  = 0;
         tail_idx  = 0;
         empty_now = 1'b1;
      endfunction

      // Out-of-range capacities clamp to the ring bounds
      function int unsigned ring_span();
         if (capacity == 0) return 1;
         if (capacity > DEPTH_DEF) return DEPTH_DEF;
         return capacity;
      endfunction

      function bit ring_full(int unsigned span_n);
         return !empty_now && ((tail_idx + 1) % span_n == head_idx);
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // A capacity write empties the deque
      function void apply_capacity(logic [CAP_W-1:0] cap);
         capacity = cap;
         clear_ring();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
         int unsigned      span_n;
         deque_result_type res;
         span_n   = ring_span();
         head_idx = head_idx % span_n;
         tail_idx = tail_idx % span_n;
         res.accepted = 1'b0;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
               if (!ring_full(span_n)) begin
                  // First entry always lands in slot zero
                  if (empty_now) begin
                     head_idx  = 0;
                     tail_idx  = 0;
                     empty_now = 1'b0;
                     ring[0]   = value;
                  end else if (op == OP_PUSH_FRONT) begin
                     head_idx       = (head_idx + span_n - 1) % span_n;
                     ring[head_idx] = value;
                  end else begin
                     tail_idx       = (tail_idx + 1) % span_n;
                     ring[tail_idx] = value;
                  end
                  res.accepted = 1'b1;
               end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
               if (!empty_now) begin
                  // Removing the only entry keeps head and tail in place
                  if (head_idx == tail_idx) empty_now = 1'b1;
                  else if (op == OP_POP_FRONT) head_idx = (head_idx + 1) % span_n;
                  else tail_idx = (tail_idx + span_n - 1) % span_n;
                  res.accepted = 1'b1;
               end
            end
            OP_PEEK: res.accepted = 1'b1;
            default: ;
         endcase
         res.front_value = empty_now ? '1 : ring[head_idx];
         res.rear_value  = empty_now ? '1 : ring[tail_idx];
         res.is_empty    = empty_now;
         res.is_full     = ring_full(span_n);
         awaited.push_back(res);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] word);
         deque_result_type want, got;
         got.accepted    = word[0];
         got.front_value = word[32:1];
         got.rear_value  = word[64:33];
         got.is_empty    = word[65];
         got.is_full     = word[66];
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR %0t: response with no request outstanding, tdata %h",
                        $realtime, word);
            return;
         end
         want = awaited.pop_front();
         if (got.accepted !== want.accepted || got.front_value !== want.front_value ||
             got.rear_value !== want.rear_value || got.is_empty !== want.is_empty ||
             got.is_full !== want.is_full) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR %0t: expected %b %h %h %b %b, got %b %h %h %b %b",
                        $realtime,
                        want.accepted, want.front_value, want.rear_value,
                        want.is_empty, want.is_full,
                        got.accepted, got.front_value, got.rear_value,
                        got.is_empty, got.is_full);
         end
      endfunction
   endclass

   deque_scoreboard_type sb = new();

   circular_deque DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop for a hung run
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   // Check responses, then record newly accepted requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata[OP_W-1:0], req_tdata[OP_W +: DATA_W]);
      end
   end

   // Stall the response side in changing moods, with one long hold-off on demand
   initial begin : rsp_stall_pattern
      int unsigned stall_pct;
      int unsigned mood_left;
      bit          seen_toggle;
      stall_pct   = 0;
      mood_left   = 0;
      seen_toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         if (mood_left == 0) begin
            case ($urandom_range(4))
               0, 1: stall_pct = 0;
               2: stall_pct = 30;
               3: stall_pct = 60;
               default: stall_pct = 85;
            endcase
            mood_left = $urandom_range(16, 96);
         end
         mood_left--;
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one request inside a burst, opening a new burst after a random gap
   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - REQ_BITS){1'b0}}, value, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every expected response is in
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.apply_capacity(cap);
   endtask

   // Favor inserts while filling and deletes while draining
   function automatic logic [OP_W-1:0] pick_op(input bit filling);
      int unsigned roll;
      bit          front;
      roll  = $urandom_range(99);
      front = $urandom_range(1);
      if (roll < 5) return OP_PEEK;
      if (roll < 9) begin
         case ($urandom_range(2))
            0: return OP_BAD_5;
            1: return OP_BAD_6;
            default: return OP_BAD_7;
         endcase
      end
      if ((roll < 70) == filling) return front ? OP_PUSH_FRONT : OP_PUSH_REAR;
      return front ? OP_POP_FRONT : OP_POP_REAR;
   endfunction

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(19))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      logic [CAP_W-1:0] phase_caps [11];
      int unsigned      mode_left;
      bit               filling;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty deque: peek and refused deletes
      send_request(OP_PEEK, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_POP_REAR, 32'h0);
      // Extreme values at both ends
      send_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(OP_PUSH_REAR, 32'h8000_0000);
      send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      send_request(OP_PUSH_REAR, 32'h0000_0000);
      send_request(OP_PEEK, 32'hDEAD_BEEF);
      // Unknown operations change nothing
      send_request(OP_BAD_5, 32'h1234_5678);
      send_request(OP_BAD_6, 32'h0);
      send_request(OP_BAD_7, 32'hFFFF_FFFF);
      // Drain down to the last entry and past it
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_POP_REAR, 32'h0);
      send_request(OP_POP_FRONT, 32'h0);
      send_request(OP_POP_REAR, 32'h0);
      send_request(OP_POP_REAR, 32'h0);
      // Single-entry ring: full after one insert
      set_capacity(5'd1);
      send_request(OP_PUSH_REAR, 32'h5A5A_A5A5);
      send_request(OP_PUSH_FRONT, 32'h1111_1111);
      send_request(OP_POP_FRONT, 32'h0);
      // Zero capacity acts as one
      set_capacity(5'd0);
      send_request(OP_PUSH_FRONT, 32'hA5A5_5A5A);
      send_request(OP_PUSH_REAR, 32'h2222_2222);
      send_request(OP_POP_REAR, 32'h0);
      // Oversized capacity clamps to the ring depth
      set_capacity(5'd31);
      send_request(OP_PUSH_REAR, 32'h0000_0001);
      send_request(OP_PEEK, 32'h0);

      // Random phases, each under its own capacity
      phase_caps = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd5, 5'd8, 5'd0, 5'd17, 5'd31, 5'd16, 5'd16};
      phase_caps[10] = CAP_W'($urandom_range(1, 16));
      for (int p = 0; p < 11; p++) begin
         set_capacity(phase_caps[p]);
         filling   = 1'b1;
         mode_left = $urandom_range(4, 48);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Long response hold-off while requests keep coming back to back
            if (p == 9 && n == 8) begin
               hold_toggle <= ~hold_toggle;
               burst_left = 40;
            end
            // Pause the sender until the scoreboard drains
            if (p == 3 && n == 30) wait_idle();
            if (mode_left == 0) begin
               filling   = !filling;
               mode_left = $urandom_range(4, 48);
            end
            mode_left--;
            send_request(pick_op(filling), pick_value());
         end
      end

      wait_idle();
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
